// ===== rtl/core/tet_pkg.sv =====
// Shared types and constants for the text encoding transcoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tet_pkg;

   localparam int CODE_W = 31;
   localparam int BYTE_W = 8;
   localparam int FMT_W = 2;
   localparam int PEND_W = 3;

   localparam logic [FMT_W-1:0] ENC_ANSI  = 2'd0;
   localparam logic [FMT_W-1:0] ENC_UTF8  = 2'd1;
   localparam logic [FMT_W-1:0] ENC_U16LE = 2'd2;
   localparam logic [FMT_W-1:0] ENC_U16BE = 2'd3;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_FORMAT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_FORMAT = 1'b1;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic              err;
      logic [CODE_W-1:0] code;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type token;
   } item_type;

endpackage

// ===== rtl/core/tet_front.sv =====
// Front end: accepts input bytes, decodes them per the input format and
// pushes completed code points or error tokens. Depends on tet_pkg.
`timescale 1ns / 1ps

module tet_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tet_pkg::BYTE_W-1:0]           req_tdata,   // [7:0] in_byte
   input  logic                                 csr_wr_en,
   input  logic [tet_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tet_pkg::FMT_W-1:0]            csr_wdata,
   input  logic                                 q_full,
   output tet_pkg::item_type                    push
);

   logic [tet_pkg::FMT_W-1:0]  fmt_ff, fmt_in;
   logic [tet_pkg::CODE_W-1:0] acc_ff, acc_in;
   logic [tet_pkg::PEND_W-1:0] pend_ff, pend_in;
   logic                       accept;
   logic [tet_pkg::CODE_W-1:0] acc_cont;
   logic [15:0]                word;
   logic [tet_pkg::BYTE_W-1:0] b;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign acc_cont   = {acc_ff[tet_pkg::CODE_W-7:0], b[5:0]};
   assign word       = (fmt_ff == tet_pkg::ENC_U16LE) ? {b, acc_ff[7:0]} : {acc_ff[7:0], b};

   always_comb begin
      fmt_in  = fmt_ff;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      push    = '0;
      if (accept) begin
         unique case (fmt_ff)
            tet_pkg::ENC_ANSI: begin
               push.valid      = 1'b1;
               push.token.code = {{(tet_pkg::CODE_W-8){1'b0}}, b};
            end
            tet_pkg::ENC_UTF8: begin
               if (pend_ff != '0) begin
                  acc_in  = acc_cont;
                  pend_in = pend_ff - 3'd1;
                  if (pend_ff == 3'd1) begin
                     push.valid      = 1'b1;
                     push.token.code = acc_cont;
                  end
               end else if (!b[7]) begin
                  push.valid      = 1'b1;
                  push.token.code = {{(tet_pkg::CODE_W-8){1'b0}}, b};
               end else if (b[7:5] == 3'b110) begin
                  acc_in  = {{(tet_pkg::CODE_W-5){1'b0}}, b[4:0]};
                  pend_in = 3'd1;
               end else if (b[7:4] == 4'b1110) begin
                  acc_in  = {{(tet_pkg::CODE_W-4){1'b0}}, b[3:0]};
                  pend_in = 3'd2;
               end else if (b[7:3] == 5'b11110) begin
                  acc_in  = {{(tet_pkg::CODE_W-3){1'b0}}, b[2:0]};
                  pend_in = 3'd3;
               end else if (b[7:2] == 6'b111110) begin
                  acc_in  = {{(tet_pkg::CODE_W-2){1'b0}}, b[1:0]};
                  pend_in = 3'd4;
               end else if (b[7:1] == 7'b1111110) begin
                  acc_in  = {{(tet_pkg::CODE_W-1){1'b0}}, b[0]};
                  pend_in = 3'd5;
               end else begin
                  push.valid     = 1'b1;
                  push.token.err = 1'b1;
               end
            end
            default: begin
               if (pend_ff == '0) begin
                  acc_in  = {{(tet_pkg::CODE_W-8){1'b0}}, b};
                  pend_in = 3'd1;
               end else begin
                  acc_in          = {{(tet_pkg::CODE_W-16){1'b0}}, word};
                  pend_in         = '0;
                  push.valid      = 1'b1;
                  push.token.code = {{(tet_pkg::CODE_W-16){1'b0}}, word};
               end
            end
         endcase
      end
      if (csr_wr_en && csr_index == tet_pkg::CSR_IN_FORMAT) begin
         fmt_in  = csr_wdata;
         acc_in  = '0;
         pend_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= tet_pkg::ENC_ANSI;
         acc_ff  <= '0;
         pend_ff <= '0;
      end else begin
         fmt_ff  <= fmt_in;
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// ===== rtl/core/tet_queue.sv =====
// Short token queue between the decode front end and the encode back end.
// Depends on tet_pkg.
`timescale 1ns / 1ps

module tet_queue #(
   parameter int DEPTH = tet_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  tet_pkg::item_type push,
   input  logic              pop,
   output logic              full,
   output tet_pkg::item_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tet_pkg::token_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign do_push    = push.valid && !full;
   assign head.valid = (count_ff != '0);
   assign head.token = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/tet_back.sv =====
// Back end: takes tokens from the queue and emits the output bytes one per
// cycle, unless stalled, through a registered output stage. Depends on tet_pkg.
`timescale 1ns / 1ps

module tet_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tet_pkg::FMT_W-1:0]      csr_wdata,
   input  tet_pkg::item_type              head,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tet_pkg::BYTE_W-1:0]     rsp_tdata,   // [7:0] out_byte
   output logic                           rsp_tlast,   // last_byte
   output logic                           rsp_tuser    // [0] error
);

   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] LEAD4 = 8'hF0;
   localparam logic [7:0] LEAD5 = 8'hF8;
   localparam logic [7:0] LEAD6 = 8'hFC;

   logic [tet_pkg::FMT_W-1:0]  fmt_ff, fmt_in;
   logic                       wk_valid_ff, wk_valid_in;
   tet_pkg::token_type         wk_tok_ff, wk_tok_in;
   logic [2:0]                 wk_cnt_ff, wk_cnt_in;
   logic [2:0]                 wk_idx_ff, wk_idx_in;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_err_ff, out_err_in;

   logic                       out_load;
   logic                       wk_last;
   logic                       wk_done;
   logic [2:0]                 sh;
   logic [7:0]                 chunk;
   logic [7:0]                 lead;
   logic [7:0]                 cur_byte;
   logic [tet_pkg::CODE_W-1:0] v;
   logic [2:0]                 head_len;

   function automatic logic [2:0] out_len(input tet_pkg::token_type t,
                                          input logic [tet_pkg::FMT_W-1:0] f);
      logic [2:0] n;
      n = 3'd1;
      if (!t.err) begin
         unique case (f)
            tet_pkg::ENC_ANSI: n = 3'd1;
            tet_pkg::ENC_UTF8: begin
               if (t.code <= 31'h7F) begin
                  n = 3'd1;
               end else if (t.code <= 31'h7FF) begin
                  n = 3'd2;
               end else if (t.code <= 31'hFFFF) begin
                  n = 3'd3;
               end else if (t.code <= 31'h1FFFFF) begin
                  n = 3'd4;
               end else if (t.code <= 31'h3FFFFFF) begin
                  n = 3'd5;
               end else begin
                  n = 3'd6;
               end
            end
            default: n = 3'd2;
         endcase
      end
      return n;
   endfunction

   assign v        = wk_tok_ff.code;
   assign wk_last  = (wk_idx_ff == wk_cnt_ff - 3'd1);
   assign out_load = wk_valid_ff && (!out_valid_ff || rsp_tready);
   assign wk_done  = out_load && wk_last;
   assign pop      = head.valid && (!wk_valid_ff || wk_done);
   assign head_len = out_len(head.token, fmt_ff);
   assign sh       = wk_cnt_ff - 3'd1 - wk_idx_ff;

   always_comb begin
      unique case (sh)
         3'd0:    chunk = v[7:0];
         3'd1:    chunk = v[13:6];
         3'd2:    chunk = v[19:12];
         3'd3:    chunk = v[25:18];
         3'd4:    chunk = {1'b0, v[30:24]};
         3'd5:    chunk = {7'b0, v[30]};
         default: chunk = '0;
      endcase
   end

   always_comb begin
      unique case (wk_cnt_ff)
         3'd2:    lead = LEAD2;
         3'd3:    lead = LEAD3;
         3'd4:    lead = LEAD4;
         3'd5:    lead = LEAD5;
         3'd6:    lead = LEAD6;
         default: lead = '0;
      endcase
   end

   always_comb begin
      cur_byte = '0;
      if (!wk_tok_ff.err) begin
         unique case (fmt_ff)
            tet_pkg::ENC_ANSI:  cur_byte = v[7:0];
            tet_pkg::ENC_U16LE: cur_byte = (wk_idx_ff == '0) ? v[7:0] : v[15:8];
            tet_pkg::ENC_U16BE: cur_byte = (wk_idx_ff == '0) ? v[15:8] : v[7:0];
            default: begin
               if (wk_cnt_ff == 3'd1) begin
                  cur_byte = v[7:0];
               end else if (wk_idx_ff == '0) begin
                  cur_byte = lead | chunk;
               end else begin
                  cur_byte = 8'h80 | {2'b00, chunk[5:0]};
               end
            end
         endcase
      end
   end

   always_comb begin
      fmt_in       = fmt_ff;
      wk_valid_in  = wk_valid_ff;
      wk_tok_in    = wk_tok_ff;
      wk_cnt_in    = wk_cnt_ff;
      wk_idx_in    = wk_idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      if (pop) begin
         wk_valid_in = 1'b1;
         wk_tok_in   = head.token;
         wk_cnt_in   = head_len;
         wk_idx_in   = '0;
      end else if (wk_done) begin
         wk_valid_in = 1'b0;
      end else if (out_load) begin
         wk_idx_in = wk_idx_ff + 3'd1;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = wk_last;
         out_err_in   = wk_tok_ff.err;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (csr_wr_en && csr_index == tet_pkg::CSR_OUT_FORMAT) begin
         fmt_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      wk_tok_ff   <= wk_tok_in;
      wk_cnt_ff   <= wk_cnt_in;
      wk_idx_ff   <= wk_idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= tet_pkg::ENC_ANSI;
         wk_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         wk_valid_ff  <= wk_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

// ===== rtl/core/text_encoding_transcoder.sv =====
// The first output byte of a code point passes through the token queue, the
// working register and the registered output stage once the request that
// completes it is accepted. The encode stage emits one output byte per cycle
// while rsp_tready is high; a request is accepted every cycle while the token
// queue has room, so the output bytes per code point bound the input rate.
// Reset: synchronous; formats return to ANSI and any open sequence is dropped.
`timescale 1ns / 1ps

module text_encoding_transcoder #(
   parameter int QUEUE_DEPTH = tet_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tet_pkg::BYTE_W-1:0]     req_tdata,   // [7:0] in_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tet_pkg::BYTE_W-1:0]     rsp_tdata,   // [7:0] out_byte
   output logic                           rsp_tlast,   // last_byte
   output logic                           rsp_tuser,   // [0] error
   input  logic                           csr_wr_en,
   input  logic [tet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tet_pkg::FMT_W-1:0]      csr_wdata
);

   tet_pkg::item_type push;
   tet_pkg::item_type head;
   logic              q_full;
   logic              pop;

   tet_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .push       (push)
   );

   tet_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   tet_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/tet_checker.sv =====
// Port-level checks for the text encoding transcoder, bound to the top level.
// Depends on tet_pkg and text_encoding_transcoder.
`timescale 1ns / 1ps

module tet_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [tet_pkg::BYTE_W-1:0] rsp_tdata,
   input logic                       rsp_tlast,
   input logic                       rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0 && rsp_tlast)
      else $error("error request not a single zero byte");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req not ready after reset");

endmodule

bind text_encoding_transcoder tet_checker u_tet_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
